// ----- rtl/stbs_pkg.sv -----
// Shared types and constants for the sorted-table binary search block.
package stbs_pkg;

    localparam int IDX_W   = 10;  // entry_index and match_index width
    localparam int VAL_W   = 32;  // table entry and key width
    localparam int CNT_W   = 6;   // comparison_count width
    localparam int NUM_W   = 11;  // entries_in_use width, also search bounds
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic       REQ_LOAD   = 1'b0;
    localparam logic       REQ_SEARCH = 1'b1;
    localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

    // Comparisons charged when a probe ends on the equality test, the bound
    // test, or runs through the order test.
    localparam logic [CNT_W-1:0] CNT_EQ    = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_BOUND = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_ORDER = CNT_W'(3);

    typedef struct packed {
        logic load;    // write the request's entry into the table
        logic start;   // capture key, open the range
        logic rd;      // read the middle entry
        logic step;    // narrow the range after a probe
        logic finish;  // write the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic eq;      // middle entry equals key
        logic last;    // range holds one entry
        logic empty;   // no entries in use
    } dp_sts_t;

endpackage

// ----- rtl/stbs_req_if.sv -----
// Request channel: valid/ready handshake with load and search payload.
interface stbs_req_if;
    import stbs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [IDX_W-1:0]         entry_index;
    logic signed [VAL_W-1:0]  entry_value;
    logic signed [VAL_W-1:0]  search_key;

    modport source (output valid, req_type, entry_index, entry_value, search_key,
                    input ready);
    modport sink   (input valid, req_type, entry_index, entry_value, search_key,
                    output ready);
endinterface

// ----- rtl/stbs_rsp_if.sv -----
// Result channel: valid/ready handshake with search result payload.
interface stbs_rsp_if;
    import stbs_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic [CNT_W-1:0] comparison_count;

    modport source (output valid, found, match_index, comparison_count,
                    input ready);
    modport sink   (input valid, found, match_index, comparison_count,
                    output ready);
endinterface

// ----- rtl/sorted_table_binary_search_core.sv -----
// Top level of the sorted-table binary search block with its register port.
//
// A load item writes one table entry. A search item makes P probes, where
// P is at most ceil(log2(n)) + 1 for n entries in use, and none for an
// empty table. Each probe is a read of the single-port table memory
// followed by a compare state that narrows the range; the last probe waits
// there until the output register is free. One item is in work at a time;
// a finished result sits in an output register, and the next item is taken
// while it waits. Table entries hold no reset value, so a search must cover
// only loaded entries. Register entries_in_use lies at byte address 0.
module sorted_table_binary_search_core
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    stbs_req_if.sink           req,
    stbs_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [NUM_W-1:0] entries_in_use_reg, entries_in_use_next;
    logic [0:0]       reg_sel;
    dp_cmd_t          cmd;
    dp_sts_t          sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_comb
    begin
        entries_in_use_next = entries_in_use_reg;
        if (psel && penable && pwrite && pready && reg_sel == REG_ENTRIES_IN_USE)
            entries_in_use_next = pwdata[NUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entries_in_use_reg <= '0;
        else
            entries_in_use_reg <= entries_in_use_next;
    end

    assign prdata = (reg_sel == REG_ENTRIES_IN_USE)
                    ? PDATA_W'(entries_in_use_reg) : '0;

    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk              (clk),
        .cmd              (cmd),
        .sts              (sts),
        .entries_in_use   (entries_in_use_reg),
        .entry_index      (req.entry_index),
        .entry_value      (req.entry_value),
        .search_key       (req.search_key),
        .found            (rsp.found),
        .match_index      (rsp.match_index),
        .comparison_count (rsp.comparison_count)
    );

endmodule

// ----- rtl/stbs_ctrl.sv -----
// Search sequencer: accepts items, steps probes, hands results to the output register.
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic    req_type,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_EMPTY = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       accept;
    logic       out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_SEARCH)
                    begin
                        cmd.start  = 1'b1;
                        state_next = sts.empty ? S_EMPTY : S_READ;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.eq || sts.last)
                begin
                    // hold the probe until the output register is free
                    if (out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- rtl/stbs_dpath.sv -----
// Search datapath: table memory, range bounds, probe compare and result register.
module stbs_dpath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic                    clk,
    input  dp_cmd_t                 cmd,
    output dp_sts_t                 sts,
    input  logic [NUM_W-1:0]        entries_in_use,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic signed [VAL_W-1:0] entry_value,
    input  logic signed [VAL_W-1:0] search_key,
    output logic                    found,
    output logic [IDX_W-1:0]        match_index,
    output logic [CNT_W-1:0]        comparison_count
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic signed [VAL_W-1:0] table_mem [TABLE_DEPTH];

    logic signed [VAL_W-1:0] key_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic [NUM_W-1:0]        lo_reg, hi_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        match_reg;
    logic [CNT_W-1:0]        cnt_out_reg;

    logic [NUM_W-1:0]        num_used;
    logic [NUM_W-1:0]        mid;
    logic                    load_ok;

    // clamp the entry count to the table size
    assign num_used = (32'(entries_in_use) > TABLE_DEPTH) ? NUM_W'(TABLE_DEPTH)
                                                          : entries_in_use;
    assign mid      = NUM_W'((({1'b0, lo_reg} + {1'b0, hi_reg})) >> 1);
    assign load_ok  = 32'(entry_index) < TABLE_DEPTH;

    assign sts.eq    = (rd_data_reg == key_reg);
    assign sts.last  = (lo_reg >= hi_reg);
    assign sts.empty = (num_used == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
            table_mem[ADDR_W'(entry_index)] <= entry_value;
        if (cmd.rd)
            rd_data_reg <= table_mem[ADDR_W'(mid)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= search_key;
            lo_reg  <= '0;
            hi_reg  <= num_used - NUM_W'(1);
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            // keep the lower part with the middle, or the upper part after it
            if (rd_data_reg > key_reg)
                hi_reg <= mid;
            else
                lo_reg <= mid + NUM_W'(1);
            cnt_reg <= cnt_reg + CNT_ORDER;
        end

        if (cmd.finish)
        begin
            if (sts.empty)
            begin
                found_reg   <= 1'b0;
                match_reg   <= '0;
                cnt_out_reg <= '0;
            end
            else
            begin
                found_reg   <= sts.eq;
                match_reg   <= sts.eq ? mid[IDX_W-1:0] : '0;
                cnt_out_reg <= cnt_reg + (sts.eq ? CNT_EQ : CNT_BOUND);
            end
        end
    end

    assign found            = found_reg;
    assign match_index      = match_reg;
    assign comparison_count = cnt_out_reg;

endmodule

// ----- rtl/stbs_checker.sv -----
// Port-level checks of the search block, bound to the top level.
module stbs_checker
    import stbs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             req_type,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             found,
    input logic [IDX_W-1:0] match_index,
    input logic [CNT_W-1:0] comparison_count
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(found)
            && $stable(match_index) && $stable(comparison_count))
        else $error("result changed while stalled");

    // a search occupies the block for at least the next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_SEARCH |=> !req_ready)
        else $error("item taken during a search");

    // a hit ends on an equality test, so it made at least one comparison
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> comparison_count != '0)
        else $error("hit with no comparisons");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> match_index == '0)
        else $error("miss with nonzero index");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_type         (req.req_type),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .found            (rsp.found),
    .match_index      (rsp.match_index),
    .comparison_count (rsp.comparison_count)
);
